// ===== src/deq_pkg.sv =====
// deq_pkg: shared constants, codes and types for the double-ended queue
// depends on nothing; used by deq_ctrl, deq_datapath and double_ended_queue
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 8;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W      = COUNT_W + 1;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;
    localparam int OP_W   = 3;

    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [COUNT_W-1:0]    count_t;
    typedef logic [SUM_W-1:0]      sum_t;
    typedef logic [CMD_W-1:0]      cmd_t;
    typedef logic [STAT_W-1:0]     stat_t;
    typedef logic [OP_W-1:0]       op_t;

    // command codes on the input channel
    localparam cmd_t CMD_PUSH_FRONT = 3'd0;
    localparam cmd_t CMD_PUSH_BACK  = 3'd1;
    localparam cmd_t CMD_POP_FRONT  = 3'd2;
    localparam cmd_t CMD_POP_BACK   = 3'd3;
    localparam cmd_t CMD_QUERY      = 3'd4;

    // status codes on the output channel
    localparam stat_t STAT_DONE       = 2'd0;
    localparam stat_t STAT_POP_EMPTY  = 2'd1;
    localparam stat_t STAT_PUSH_FULL  = 2'd2;

    // datapath operations
    localparam op_t OP_NONE       = 3'd0;
    localparam op_t OP_PUSH_FRONT = 3'd1;
    localparam op_t OP_PUSH_BACK  = 3'd2;
    localparam op_t OP_POP_FRONT  = 3'd3;
    localparam op_t OP_POP_BACK   = 3'd4;

    typedef struct packed {
        logic capture;
        op_t  op;
        logic read_en;
    } dp_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/deq_datapath.sv =====
// deq_datapath: circular entry store, head/tail pointers, fill count, read registers
// depends on deq_pkg; driven by commands from deq_ctrl
`default_nettype none

module deq_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire deq_pkg::dp_cmd_t  cmd,
    input  wire logic [31:0]       data_word,
    output deq_pkg::dp_stat_t      stat,
    output logic [31:0]            front_value,
    output logic [31:0]            back_value,
    output logic [3:0]             item_count
);

    deq_pkg::data_t  mem [deq_pkg::DEPTH];
    deq_pkg::data_t  data_reg;
    deq_pkg::data_t  front_rd_reg;
    deq_pkg::data_t  back_rd_reg;
    deq_pkg::addr_t  head_reg;
    deq_pkg::addr_t  head_next;
    deq_pkg::addr_t  tail_reg;
    deq_pkg::addr_t  tail_next;
    deq_pkg::count_t count_reg;
    deq_pkg::count_t count_next;
    deq_pkg::addr_t  head_inc;
    deq_pkg::addr_t  head_dec;
    deq_pkg::addr_t  tail_inc;
    deq_pkg::addr_t  tail_dec;
    deq_pkg::sum_t   wrap_sum;
    deq_pkg::sum_t   wrap_pos;
    logic            empty;
    logic            full;

    always_comb
    begin
        head_inc = (head_reg == deq_pkg::addr_t'(deq_pkg::DEPTH - 1)) ? '0
                 : head_reg + deq_pkg::addr_t'(1);
        head_dec = (head_reg == '0) ? deq_pkg::addr_t'(deq_pkg::DEPTH - 1)
                 : head_reg - deq_pkg::addr_t'(1);
        tail_inc = (tail_reg == deq_pkg::addr_t'(deq_pkg::DEPTH - 1)) ? '0
                 : tail_reg + deq_pkg::addr_t'(1);
        tail_dec = (tail_reg == '0) ? deq_pkg::addr_t'(deq_pkg::DEPTH - 1)
                 : tail_reg - deq_pkg::addr_t'(1);
    end

    assign empty = (count_reg == '0);
    assign full  = (count_reg == deq_pkg::count_t'(deq_pkg::DEPTH));

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        unique case (cmd.op)
            deq_pkg::OP_PUSH_FRONT:
            begin
                head_next  = head_dec;
                count_next = count_reg + deq_pkg::count_t'(1);
            end
            deq_pkg::OP_PUSH_BACK:
            begin
                tail_next  = tail_inc;
                count_next = count_reg + deq_pkg::count_t'(1);
            end
            deq_pkg::OP_POP_FRONT:
            begin
                head_next  = head_inc;
                count_next = count_reg - deq_pkg::count_t'(1);
            end
            deq_pkg::OP_POP_BACK:
            begin
                tail_next  = tail_dec;
                count_next = count_reg - deq_pkg::count_t'(1);
            end
            default:
            begin
                head_next  = head_reg;
                tail_next  = tail_reg;
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            data_reg <= deq_pkg::data_t'(data_word);
        end
    end

    // entry store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.op == deq_pkg::OP_PUSH_FRONT)
        begin
            mem[head_dec] <= data_reg;
        end
        else if (cmd.op == deq_pkg::OP_PUSH_BACK)
        begin
            mem[tail_reg] <= data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_en)
        begin
            front_rd_reg <= mem[head_reg];
            back_rd_reg  <= mem[tail_dec];
        end
    end

    assign stat.empty  = empty;
    assign stat.full   = full;
    assign front_value = empty ? '0 : 32'(front_rd_reg);
    assign back_value  = empty ? '0 : 32'(back_rd_reg);
    assign item_count  = 4'(count_reg);

    assign wrap_sum = deq_pkg::sum_t'(head_reg) + deq_pkg::sum_t'(count_reg);
    assign wrap_pos = (wrap_sum >= deq_pkg::sum_t'(deq_pkg::DEPTH))
                    ? wrap_sum - deq_pkg::sum_t'(deq_pkg::DEPTH) : wrap_sum;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= deq_pkg::count_t'(deq_pkg::DEPTH))
        else $error("fill count above capacity");

    a_ptr_relation: assert property (@(posedge clk) disable iff (!rst_n)
        wrap_pos == deq_pkg::sum_t'(tail_reg))
        else $error("head plus count does not reach tail");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == deq_pkg::OP_PUSH_FRONT || cmd.op == deq_pkg::OP_PUSH_BACK) |-> !full)
        else $error("push issued on full store");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == deq_pkg::OP_POP_FRONT || cmd.op == deq_pkg::OP_POP_BACK) |-> !empty)
        else $error("pop issued on empty store");

endmodule

`default_nettype wire

// ===== src/deq_ctrl.sv =====
// deq_ctrl: handshake state machine and command decode for the double-ended queue
// depends on deq_pkg; drives deq_datapath through dp_cmd_t
`default_nettype none

module deq_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        command,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    input  wire deq_pkg::dp_stat_t stat,
    output deq_pkg::dp_cmd_t       cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]     state_reg;
    logic [1:0]     state_next;
    deq_pkg::op_t   op_reg;
    deq_pkg::op_t   op_next;
    deq_pkg::stat_t status_reg;
    deq_pkg::stat_t status_next;
    logic           in_xfer;
    logic           out_xfer;

    assign in_xfer  = in_valid && (state_reg == ST_IDLE);
    assign out_xfer = (state_reg == ST_OUT) && !out_stall;

    always_comb
    begin
        op_next     = deq_pkg::OP_NONE;
        status_next = deq_pkg::STAT_DONE;
        unique case (command) inside
            deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK:
            begin
                if (stat.full)
                begin
                    status_next = deq_pkg::STAT_PUSH_FULL;
                end
                else
                begin
                    op_next = (command == deq_pkg::CMD_PUSH_FRONT)
                            ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
                end
            end
            deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK:
            begin
                if (stat.empty)
                begin
                    status_next = deq_pkg::STAT_POP_EMPTY;
                end
                else
                begin
                    op_next = (command == deq_pkg::CMD_POP_FRONT)
                            ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
                end
            end
            default:
            begin
                op_next     = deq_pkg::OP_NONE;
                status_next = deq_pkg::STAT_DONE;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: state_next = in_valid ? ST_EXEC : ST_IDLE;
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_OUT;
            ST_OUT:  state_next = out_stall ? ST_OUT : ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= deq_pkg::OP_NONE;
            status_reg <= deq_pkg::STAT_DONE;
        end
        else
        begin
            state_reg <= state_next;
            if (in_xfer)
            begin
                op_reg     <= op_next;
                status_reg <= status_next;
            end
        end
    end

    assign cmd.capture = in_xfer;
    assign cmd.op      = (state_reg == ST_EXEC) ? op_reg : deq_pkg::OP_NONE;
    assign cmd.read_en = (state_reg == ST_READ);

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign status    = status_reg;

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == ST_EXEC)
        else $error("accepted transfer not executed");

    a_out_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |=> !out_valid && !in_stall)
        else $error("result transfer did not free the block");

    a_read_before_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.read_en))
        else $error("result shown without store read");

endmodule

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// double_ended_queue: one item in flight; result presented after the item is executed and the store is read
// sequence: accept, update pointers and write entry, read front/back, present result
// flow: the next item is accepted only once the result has been taken; paced by the store write-then-read
// reset: rst_n asynchronous, empties the queue (head, tail, count zero); store not cleared
// depends on deq_pkg, deq_ctrl, deq_datapath
`default_nettype none

module double_ended_queue (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  command,
    input  wire logic [31:0] data_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      front_value,
    output logic [31:0]      back_value,
    output logic [3:0]       item_count,
    output logic             is_empty,
    output logic             is_full,
    output logic [1:0]       status
);

    deq_pkg::dp_cmd_t  dp_cmd;
    deq_pkg::dp_stat_t dp_stat;

    deq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    deq_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (dp_cmd),
        .data_word   (data_word),
        .stat        (dp_stat),
        .front_value (front_value),
        .back_value  (back_value),
        .item_count  (item_count)
    );

    assign is_empty = dp_stat.empty;
    assign is_full  = dp_stat.full;

endmodule

`default_nettype wire
